// ===== design/iis_pkg.sv =====
// Shared types and constants of the integral image stream core.
package iis_pkg;

    // Fixed widths and sizes: channel count, pixel and result words, configuration fields and counters.
    localparam int NUM_CH     = 4;
    localparam int PIXEL_BITS = 8;
    localparam int SUM_W      = 32;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CCNT_W     = 3;
    localparam int ROW_W      = 12;
    localparam int MAX_HEIGHT = 4096;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CHANNELS = 2'd2;

    // Register values after reset.
    localparam logic [CFG_W-1:0]  RST_WIDTH    = 13'd640;
    localparam logic [CFG_W-1:0]  RST_HEIGHT   = 13'd480;
    localparam logic [CCNT_W-1:0] RST_CHANNELS = 3'd1;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] sample_ch0;
        logic [PIXEL_BITS-1:0] sample_ch1;
        logic [PIXEL_BITS-1:0] sample_ch2;
        logic [PIXEL_BITS-1:0] sample_ch3;
    } t_in_word;

    typedef struct packed {
        logic [SUM_W-1:0] area_sum_ch0;
        logic [SUM_W-1:0] area_sum_ch1;
        logic [SUM_W-1:0] area_sum_ch2;
        logic [SUM_W-1:0] area_sum_ch3;
        logic             row_end;
        logic             frame_end;
    } t_out_word;

    // Position flags of one pixel, produced by the position counters.
    typedef struct packed {
        logic first_row;
        logic row_end;
        logic frame_end;
    } t_pos_flags;

endpackage

// ===== design/iis_ctrl.sv =====
// Configuration registers and the column and row counters of the pixel stream.
module iis_ctrl import iis_pkg::*; #(
    parameter int MAX_WIDTH    = 4096,
    parameter int MAX_CHANNELS = 4,
    localparam int COL_W       = $clog2(MAX_WIDTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_accept,
    output logic [COL_W-1:0]     o_col,
    output t_pos_flags           o_flags,
    output logic [NUM_CH-1:0]    o_ch_en
);

    localparam int WCNT_W = $clog2(MAX_WIDTH + 1);

    logic [CFG_W-1:0]  r_width;
    logic [CFG_W-1:0]  r_height;
    logic [CCNT_W-1:0] r_channels;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;

    logic [WCNT_W-1:0] w_eff;
    logic [CFG_W-1:0]  h_eff;
    logic [CCNT_W-1:0] cc_eff;
    logic [COL_W-1:0]  col;
    logic              last_col;
    logic              last_row;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= RST_WIDTH;
            r_height   <= RST_HEIGHT;
            r_channels <= RST_CHANNELS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IDX_WIDTH:    r_width    <= i_cfg_data;
                CFG_IDX_HEIGHT:   r_height   <= i_cfg_data;
                CFG_IDX_CHANNELS: r_channels <= i_cfg_data[CCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Out-of-range register values are pulled into range: zero acts as one.
    always_comb begin
        if (r_width == '0) begin
            w_eff = WCNT_W'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_eff = WCNT_W'(MAX_WIDTH);
        end else begin
            w_eff = WCNT_W'(r_width);
        end

        if (r_height == '0) begin
            h_eff = CFG_W'(1);
        end else if (32'(r_height) > 32'(MAX_HEIGHT)) begin
            h_eff = CFG_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end

        if (r_channels == '0) begin
            cc_eff = CCNT_W'(1);
        end else if (32'(r_channels) > 32'(MAX_CHANNELS)) begin
            cc_eff = CCNT_W'(MAX_CHANNELS);
        end else begin
            cc_eff = r_channels;
        end
    end

    // A column counter at or past the row end is treated as the last column.
    always_comb begin
        if (WCNT_W'(r_col) >= w_eff) begin
            col = COL_W'(w_eff - WCNT_W'(1));
        end else begin
            col = r_col;
        end
        last_col = (WCNT_W'(col) + WCNT_W'(1)) >= w_eff;
        last_row = ({1'b0, r_row} + CFG_W'(1)) >= h_eff;
    end

    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            o_ch_en[i] = CCNT_W'(i) < cc_eff;
        end
    end

    assign o_col             = col;
    assign o_flags.first_row = (r_row == '0);
    assign o_flags.row_end   = last_col;
    assign o_flags.frame_end = last_col && last_row;

    // Position counters advance on every accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= col + COL_W'(1);
            end
        end
    end

endmodule

// ===== design/iis_lane.sv =====
// One channel lane: row running sum, previous-row line store and the final add.
module iis_lane import iis_pkg::*; #(
    parameter int MAX_WIDTH = 4096,
    localparam int COL_W    = $clog2(MAX_WIDTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [COL_W-1:0]      i_col,
    input  logic [PIXEL_BITS-1:0] i_sample,
    input  logic                  i_en,
    input  logic                  i_first_row,
    input  logic                  i_last_col,
    input  logic                  i_adv,
    output logic [SUM_W-1:0]      o_result
);

    localparam int RUN_W = PIXEL_BITS + $clog2(MAX_WIDTH);

    logic [SUM_W-1:0] mem [MAX_WIDTH];

    logic [RUN_W-1:0] r_run;
    logic [RUN_W-1:0] n_run_out;
    logic [RUN_W-1:0] r_s1_run;
    logic             r_s1_en;
    logic             r_s1_first;
    logic [COL_W-1:0] r_s1_col;
    logic [SUM_W-1:0] r_rd;
    logic             r_byp;
    logic [SUM_W-1:0] r_byp_data;
    logic [SUM_W-1:0] above;

    // Running sum of this row up to and including the current pixel.
    assign n_run_out = i_en ? r_run + RUN_W'(i_sample) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (i_accept) begin
            r_run <= i_last_col ? '0 : n_run_out;
        end
    end

    // Previous-row value: forwarded when the same column was written in the cycle of its read.
    always_comb begin
        if (r_s1_first) begin
            above = '0;
        end else if (r_byp) begin
            above = r_byp_data;
        end else begin
            above = r_rd;
        end
        o_result = r_s1_en ? above + SUM_W'(r_s1_run) : '0;
    end

    // Line store and the second pipeline stage.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            mem[r_s1_col] <= o_result;
        end
        if (i_accept) begin
            r_rd       <= mem[i_col];
            r_byp      <= i_adv && (r_s1_col == i_col);
            r_byp_data <= o_result;
            r_s1_run   <= n_run_out;
            r_s1_en    <= i_en;
            r_s1_first <= i_first_row;
            r_s1_col   <= i_col;
        end
    end

endmodule

// ===== design/iis_merge.sv =====
// Output stage: gathers the lane results and position flags into one result word.
module iis_merge import iis_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [SUM_W-1:0] i_sums [NUM_CH],
    input  t_pos_flags       i_flags,
    output logic             o_take,
    output logic             o_valid,
    output t_out_word        o_word,
    input  logic             i_ready
);

    logic      r_valid;
    t_out_word r_word;

    // The register can take a new word when empty or when its word leaves.
    assign o_take  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word.area_sum_ch0 <= i_sums[0];
            r_word.area_sum_ch1 <= i_sums[1];
            r_word.area_sum_ch2 <= i_sums[2];
            r_word.area_sum_ch3 <= i_sums[3];
            r_word.row_end      <= i_flags.row_end;
            r_word.frame_end    <= i_flags.frame_end;
        end
    end

endmodule

// ===== design/integral_image_stream_core.sv =====
// Top level of the streaming integral image core: counters, channel lanes, output stage.
//
//   Channel  Handshake                   Payload
//   input    i_in_valid / o_in_ready     i_in_word  (t_in_word)
//   output   o_out_valid / i_out_ready   o_out_word (t_out_word)
//   config   i_cfg_we                    i_cfg_index, i_cfg_data
//
// One pixel word is accepted per clock while a stalled output does not hold the pipeline; its
// result passes the registered read of each lane's line store and then the output register.
// Reset clears counters and running sums; the line stores need no clearing pass.
// A stalled output holds its word and the second stage; a new word still enters
// while the second stage is empty or moves on into the output register.
module integral_image_stream_core import iis_pkg::*; #(
    parameter int MAX_WIDTH    = 4096,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_word             i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_word            o_out_word
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic                  accept;
    logic                  s1_adv;
    logic                  out_take;
    logic                  r_s1_valid;
    t_pos_flags            r_s1_flags;
    logic [COL_W-1:0]      col;
    t_pos_flags            flags;
    logic [NUM_CH-1:0]     ch_en;
    logic [PIXEL_BITS-1:0] samples [NUM_CH];
    logic [SUM_W-1:0]      sums [NUM_CH];

    // Handshake of the input side and the second stage.
    assign s1_adv     = r_s1_valid && out_take;
    assign o_in_ready = !r_s1_valid || out_take;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_flags <= flags;
        end
    end

    iis_ctrl #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .o_col       (col),
        .o_flags     (flags),
        .o_ch_en     (ch_en)
    );

    assign samples[0] = i_in_word.sample_ch0;
    assign samples[1] = i_in_word.sample_ch1;
    assign samples[2] = i_in_word.sample_ch2;
    assign samples[3] = i_in_word.sample_ch3;

    // One lane per built channel; channels beyond the build read zero.
    for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
        if (g < MAX_CHANNELS) begin : g_used
            iis_lane #(
                .MAX_WIDTH (MAX_WIDTH)
            ) u_lane (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_accept    (accept),
                .i_col       (col),
                .i_sample    (samples[g]),
                .i_en        (ch_en[g]),
                .i_first_row (flags.first_row),
                .i_last_col  (flags.row_end),
                .i_adv       (s1_adv),
                .o_result    (sums[g])
            );
        end else begin : g_absent
            assign sums[g] = '0;
        end
    end

    iis_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s1_adv),
        .i_sums  (sums),
        .i_flags (r_s1_flags),
        .o_take  (out_take),
        .o_valid (o_out_valid),
        .o_word  (o_out_word),
        .i_ready (i_out_ready)
    );

    // An accepted word always occupies the second stage in the next cycle.
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted word did not reach the second stage");

    // A frame ends only on the last pixel of a row.
    a_frame_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_word.frame_end || o_out_word.row_end))
        else $error("frame end without row end");

    // With both stages full and the output stalled, no word may enter.
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready && r_s1_valid) |-> !o_in_ready)
        else $error("input taken while the pipeline is full");

endmodule
